>>> rtl/core/led_strip_comet_animator_assert.svh
// assertion macros shared by the comet animator rtl
// depends on a clock named clk and an active-high reset named rst in scope
`ifndef LED_STRIP_COMET_ANIMATOR_ASSERT_SVH
`define LED_STRIP_COMET_ANIMATOR_ASSERT_SVH

// combinational property checked at every edge outside reset
`define LCA_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// implication from one cycle to the next, outside reset
`define LCA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/lca_pkg.sv
// shared constants, types and palette rom for the comet animator
// no dependencies
package lca_pkg;

  localparam int LedCount       = 64;
  localparam int CometLength    = 16;
  localparam int SweepsPerColor = 2;
  localparam int PaletteSize    = 24;
  localparam int PaletteFirst   = 2;

  localparam int LedW   = 6;
  localparam int ColorW = 5;
  localparam int SumW   = 8;

  // brightness shifts along and off the comet
  localparam logic [2:0] ShiftOff  = 3'd7;
  localparam logic [2:0] ShiftTail = 3'd6;
  localparam logic [2:0] ShiftMid  = 3'd5;
  localparam logic [2:0] ShiftNear = 3'd4;
  localparam logic [2:0] ShiftPeak = 3'd3;

  // comet band thresholds
  localparam int BandQuarter = CometLength / 4;
  localparam int BandTop     = CometLength - 4;
  localparam int BandHalfLo  = CometLength / 2 - 1;
  localparam int BandHalf    = CometLength / 2;

  // request to the pixel shading unit
  typedef struct packed {
    logic [LedW-1:0]   pos;
    logic [LedW-1:0]   head;
    logic [ColorW-1:0] old_idx;
    logic [ColorW-1:0] new_idx;
  } shade_req_t;

  // palette rom, indices past the end read as black
  function automatic logic [31:0] palette_color(input logic [ColorW-1:0] idx);
    logic [31:0] c;
    case (idx)
      5'd0:    c = 32'h00000000;
      5'd1:    c = 32'hffffff00;
      5'd2:    c = 32'hff000000;
      5'd3:    c = 32'h00ff0000;
      5'd4:    c = 32'h0000ff00;
      5'd5:    c = 32'hffff0000;
      5'd6:    c = 32'h00ffff00;
      5'd7:    c = 32'hff00ff00;
      5'd8:    c = 32'hff800000;
      5'd9:    c = 32'h8000ff00;
      5'd10:   c = 32'hff40a000;
      5'd11:   c = 32'h840ffe00;
      5'd12:   c = 32'h40a0ff00;
      5'd13:   c = 32'h40ff4000;
      5'd14:   c = 32'hffd00000;
      5'd15:   c = 32'hc0c0c000;
      5'd16:   c = 32'h80808000;
      5'd17:   c = 32'h80000000;
      5'd18:   c = 32'h80800000;
      5'd19:   c = 32'h00008000;
      5'd20:   c = 32'h00808000;
      5'd21:   c = 32'h4000a000;
      5'd22:   c = 32'hff007000;
      5'd23:   c = 32'h00a0ff00;
      default: c = 32'h00000000;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/core/led_strip_comet_animator.sv
// top level of the comet animator: tick handshake, frame sequencer, output register
// depends on lca_pkg, lca_frame_timer, lca_shade and the assertion header
`include "led_strip_comet_animator_assert.svh"

// Each accepted tick beat carries the millisecond count. A tick that finds no
// frame due is taken and produces nothing. A due tick starts a frame of 64
// pixel beats, LED 0 first, tlast on the final one; the single shading unit
// makes one pixel per cycle while the output is not stalled. s_tready stays low
// while a frame is being produced; the output register lets the next tick be
// taken while the final pixel still waits. The frame period register resets to
// 20 ms and may be written only while no frame is in progress.
module led_strip_comet_animator (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // now_ms [31:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // pixel_word [31:0], led_index [37:32], zero [39:38]
  output logic        m_tlast
);

  localparam logic StIdle = 1'b0;
  localparam logic StRun  = 1'b1;

  localparam logic [lca_pkg::LedW-1:0] LastLed = lca_pkg::LedW'(lca_pkg::LedCount - 1);

  logic                        state;
  logic                        state_next;
  logic [lca_pkg::LedW-1:0]    pos;
  logic [lca_pkg::LedW-1:0]    head;
  logic                        sweep;
  logic [lca_pkg::ColorW-1:0]  old_idx;
  logic [lca_pkg::ColorW-1:0]  new_idx;
  logic                        tick_accept;
  logic                        frame_due;
  logic                        load;
  logic                        frame_end;
  logic [1:0]                  sweep_inc;
  logic [lca_pkg::ColorW:0]    idx_inc;
  lca_pkg::shade_req_t         req;
  logic [31:0]                 pixel;

  assign s_tready    = (state == StIdle);
  assign tick_accept = s_tvalid && s_tready;
  assign load        = (state == StRun) && (!m_tvalid || m_tready);
  assign frame_end   = load && (pos == LastLed);

  lca_frame_timer u_timer (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .now_ms      (s_tdata),
    .tick_accept (tick_accept),
    .frame_due   (frame_due)
  );

  assign req.pos     = pos;
  assign req.head    = head;
  assign req.old_idx = old_idx;
  assign req.new_idx = new_idx;

  lca_shade u_shade (
    .req   (req),
    .pixel (pixel)
  );

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      StIdle: begin
        if (tick_accept && frame_due) state_next = StRun;
      end
      StRun: begin
        if (frame_end) state_next = StIdle;
      end
      default: state_next = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
    end else begin
      state <= state_next;
    end
  end

  // led counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (tick_accept) begin
      pos <= '0;
    end else if (load) begin
      pos <= pos + 1'b1;
    end
  end

  // head advance and palette stepping at the end of each frame
  assign sweep_inc = {1'b0, sweep} + 2'd1;
  assign idx_inc   = {1'b0, old_idx} + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      sweep   <= 1'b0;
      old_idx <= lca_pkg::ColorW'(lca_pkg::PaletteFirst);
      new_idx <= lca_pkg::ColorW'(lca_pkg::PaletteFirst);
    end else if (frame_end) begin
      if (head == LastLed) begin
        head <= '0;
        if (sweep_inc >= 2'(lca_pkg::SweepsPerColor)) begin
          sweep <= 1'b0;
          if (idx_inc >= (lca_pkg::ColorW+1)'(lca_pkg::PaletteSize)) begin
            new_idx <= lca_pkg::ColorW'(lca_pkg::PaletteFirst);
          end else begin
            new_idx <= idx_inc[lca_pkg::ColorW-1:0];
          end
        end else begin
          sweep   <= sweep_inc[0];
          old_idx <= new_idx;
        end
      end else begin
        head <= head + 1'b1;
      end
    end
  end

  // output register, one pixel beat
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {2'b00, pos, pixel};
      m_tlast <= (pos == LastLed);
    end
  end

  // checks
  `LCA_ASSERT_ALWAYS(a_busy_not_ready, !(s_tready && (state == StRun)), "tick taken mid frame")
  `LCA_ASSERT_ALWAYS(a_last_index, !(m_tvalid && m_tlast) || (m_tdata[37:32] == LastLed), "tlast off the final led")
  `LCA_ASSERT_NEXT(a_frame_done, frame_end, (state == StIdle) && m_tvalid && m_tlast, "frame did not close")
  `LCA_ASSERT_ALWAYS(a_color_range, (old_idx >= lca_pkg::ColorW'(lca_pkg::PaletteFirst)) && (new_idx < lca_pkg::ColorW'(lca_pkg::PaletteSize)), "colour index out of palette")

endmodule

>>> rtl/core/lca_frame_timer.sv
// frame period register and frame due check
// depends on lca_pkg
module lca_frame_timer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic [31:0] now_ms,
  input  logic        tick_accept,
  output logic        frame_due
);

  logic [31:0] frame_period_ms;
  logic [31:0] last_frame_ms;
  logic [31:0] deadline;

  // wrapped deadline, a frame is due strictly after it
  assign deadline  = last_frame_ms + frame_period_ms;
  assign frame_due = (deadline < now_ms);

  // period register
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_period_ms <= 32'd20;
    end else if (cfg_wr_en) begin
      frame_period_ms <= cfg_wr_data;
    end
  end

  // time of the last frame
  always_ff @(posedge clk) begin
    if (rst) begin
      last_frame_ms <= '0;
    end else if (tick_accept && frame_due) begin
      last_frame_ms <= now_ms;
    end
  end

endmodule

>>> rtl/core/lca_shade.sv
// shared pixel unit: comet brightness shift, colour pick and lane dimming
// depends on lca_pkg
module lca_shade (
  input  lca_pkg::shade_req_t req,
  output logic [31:0]         pixel
);

  logic [lca_pkg::SumW-1:0] pos_sum;
  logic [lca_pkg::SumW-1:0] head_ext;
  logic [lca_pkg::SumW-1:0] wrap_top;
  logic [lca_pkg::SumW-1:0] t;
  logic                     on_comet;
  logic [2:0]               sh;
  logic [31:0]              color;

  // offset of this led along the comet, wrapping past the strip end
  always_comb begin
    pos_sum  = {{(lca_pkg::SumW-lca_pkg::LedW){1'b0}}, req.pos}
               + lca_pkg::SumW'(lca_pkg::CometLength);
    head_ext = {{(lca_pkg::SumW-lca_pkg::LedW){1'b0}}, req.head};
    wrap_top = head_ext + lca_pkg::SumW'(lca_pkg::LedCount);
    on_comet = 1'b0;
    t        = '0;
    if (req.pos < req.head) begin
      if (pos_sum >= head_ext) begin
        on_comet = 1'b1;
        t        = pos_sum - head_ext;
      end
    end else if (pos_sum > wrap_top) begin
      on_comet = 1'b1;
      t        = pos_sum - wrap_top;
    end
  end

  // brightness band along the comet
  always_comb begin
    if (!on_comet || t >= lca_pkg::SumW'(lca_pkg::CometLength)) begin
      sh = lca_pkg::ShiftOff;
    end else if (t < lca_pkg::SumW'(lca_pkg::BandQuarter) ||
                 t > lca_pkg::SumW'(lca_pkg::BandTop)) begin
      sh = lca_pkg::ShiftTail;
    end else if (t < lca_pkg::SumW'(lca_pkg::BandHalfLo) ||
                 t > lca_pkg::SumW'(lca_pkg::BandHalf)) begin
      sh = lca_pkg::ShiftMid;
    end else if (t != lca_pkg::SumW'(lca_pkg::BandHalf)) begin
      sh = lca_pkg::ShiftNear;
    end else begin
      sh = lca_pkg::ShiftPeak;
    end
  end

  // leds behind the head show the new colour
  assign color = lca_pkg::palette_color((req.pos < req.head) ? req.new_idx : req.old_idx);

  // each byte lane shifted on its own, low byte stays clear
  assign pixel = {color[31:24] >> sh, color[23:16] >> sh, color[15:8] >> sh, 8'h00};

endmodule
